// ----- sv/axis_rotation_displacement_core_defines.svh -----
`ifndef AXIS_ROTATION_DISPLACEMENT_CORE_DEFINES_SVH
`define AXIS_ROTATION_DISPLACEMENT_CORE_DEFINES_SVH

// Assertion helpers. Both expect i_clk and i_rst_n in the scope where they are used.

// Same-cycle implication, disabled while reset is asserted.
`define ARD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("axis rotation displacement check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ARD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("axis rotation displacement check failed");

`endif

// ----- sv/ard_pkg.sv -----
package ard_pkg;

    // Unit values (axis, cosine, sine) always carry this many fraction bits.
    localparam int UNIT_FRAC  = 16;
    localparam int RND_HALF   = 1 << (UNIT_FRAC - 1);

    localparam int COORD_W    = 32;
    localparam int UNIT_W     = 18;
    localparam int WEIGHT_W   = 18;
    localparam int ID_W       = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Stream payload widths; the input data width is rounded up to whole bytes.
    localparam int IN_FIELDS_W  = ID_W + 3 * COORD_W + WEIGHT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ID_W + 3 * COORD_W;
    localparam int OUT_TUSER_W  = 1;

    // Cosine reset value: 1.0 in Q1.16.
    localparam logic [UNIT_W-1:0] COS_RESET = UNIT_W'(1 << UNIT_FRAC);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_AXIS_X   = 3'd3,
        REG_AXIS_Y   = 3'd4,
        REG_AXIS_Z   = 3'd5,
        REG_COS      = 3'd6,
        REG_SIN      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] origin;
        logic [2:0][UNIT_W-1:0]  axis;
        logic [UNIT_W-1:0]       cos_a;
        logic [UNIT_W-1:0]       sin_a;
    } t_cfg;

endpackage

// ----- sv/axis_rotation_displacement_core.sv -----
// Throughput: one vertex per cycle; seven register stages each hold one vertex, and a
// stage only waits when the stage after it is full and cannot move on.
// Reset (i_rst_n low at a rising edge) empties the pipeline and returns the axis
// registers to their defaults: origin and axis zero, cosine 1.0, sine zero.
module axis_rotation_displacement_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ard_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ard_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    // Vertex stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // From bit 0: vertex_id[31:0], vertex_x[31:0], vertex_y[31:0], vertex_z[31:0],
    // weight[17:0], then zero padding up to a whole byte.
    input  logic [ard_pkg::IN_TDATA_W-1:0]  s_axis_tdata,

    // Displacement stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // From bit 0: out_id[31:0], disp_x[31:0], disp_y[31:0], disp_z[31:0].
    output logic [ard_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // From bit 0: saturated.
    output logic [ard_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import ard_pkg::*;

    `include "axis_rotation_displacement_core_defines.svh"

    // Pipeline overview (one vertex per stage):
    //   stage 0: p = vertex - origin (33 bits, exact)
    //   stage 1: all products with p: axis*p for the dot product and the cross
    //            product, cos*p, and axis*(1 - cos)
    //   stage 2: round the dot product, the cross product and k = axis*(1 - cos);
    //            form cos*p - p, which needs no further rounding
    //   stage 3: k*dot and sin*cross
    //   stage 4: sum the three terms and round back to coordinate format
    //   stage 5: multiply by the weight
    //   stage 6: round and clamp to 32 bits; this is the output register
    localparam int NSTG  = 7;
    localparam int P_W   = COORD_W + 1;              // vertex - origin
    localparam int OMC_W = UNIT_W + 1;               // 1.0 - cos
    localparam int DP_W  = UNIT_W + P_W;             // unit * p
    localparam int KP_W  = UNIT_W + OMC_W;           // axis * (1 - cos)
    localparam int DS_W  = DP_W + 3;                 // sum of three products plus rounding
    localparam int DOT_W = DS_W - UNIT_FRAC;
    localparam int CS_W  = DP_W + 2;                 // difference of two products plus rounding
    localparam int CR_W  = CS_W - UNIT_FRAC;
    localparam int KS_W  = KP_W + 1;
    localparam int K_W   = KS_W - UNIT_FRAC;
    localparam int A_W   = DP_W + 1;                 // cos*p - p scaled by 1.0
    localparam int KD_W  = K_W + DOT_W;
    localparam int SC_W  = UNIT_W + CR_W;
    localparam int S_W   = KD_W + 2;
    // The rotated sum stays below 2^55 for every register pattern, so the rounded
    // error term fits in 44 bits without loss.
    localparam int E_W   = 44;
    localparam int EW_W  = E_W + WEIGHT_W;
    localparam int Q_W   = EW_W + 1 - UNIT_FRAC;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_cfg w_cfg;

    ard_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    logic signed [COORD_W-1:0] w_org [3];
    logic signed [UNIT_W-1:0]  w_ax  [3];
    logic signed [UNIT_W-1:0]  w_cos;
    logic signed [UNIT_W-1:0]  w_sin;
    logic signed [OMC_W-1:0]   w_omc;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_org[i] = $signed(w_cfg.origin[i]);
            w_ax[i]  = $signed(w_cfg.axis[i]);
        end
        w_cos = $signed(w_cfg.cos_a);
        w_sin = $signed(w_cfg.sin_a);
        w_omc = $signed(OMC_W'(1 << UNIT_FRAC)) - $signed({w_cos[UNIT_W-1], w_cos});
    end

    // ------------------------------------------------------------------
    // Flow control: each stage moves when it is empty or the next stage moves,
    // so bubbles close up while the output is stalled.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: translate the vertex into the axis frame.
    // ------------------------------------------------------------------
    logic [ID_W-1:0]            r0_id;
    logic signed [WEIGHT_W-1:0] r0_w;
    logic signed [P_W-1:0]      r0_p [3];
    logic [COORD_W-1:0]         w_vtx [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_vtx[i] = s_axis_tdata[ID_W + i * COORD_W +: COORD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_id <= s_axis_tdata[ID_W-1:0];
            r0_w  <= $signed(s_axis_tdata[ID_W + 3 * COORD_W +: WEIGHT_W]);
            for (int i = 0; i < 3; i++) begin
                r0_p[i] <= $signed({w_vtx[i][COORD_W-1], w_vtx[i]})
                         - $signed({w_org[i][COORD_W-1], w_org[i]});
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: products with p.
    // ------------------------------------------------------------------
    logic [ID_W-1:0]            r1_id;
    logic signed [WEIGHT_W-1:0] r1_w;
    logic signed [P_W-1:0]      r1_p  [3];
    logic signed [DP_W-1:0]     r1_dp [3];   // axis_i * p_i
    logic signed [DP_W-1:0]     r1_xa [3];   // first cross product term
    logic signed [DP_W-1:0]     r1_xb [3];   // second cross product term
    logic signed [DP_W-1:0]     r1_cp [3];   // cos * p_i
    logic signed [KP_W-1:0]     r1_kp [3];   // axis_i * (1 - cos)

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_id <= r0_id;
            r1_w  <= r0_w;
            for (int i = 0; i < 3; i++) begin
                r1_p[i]  <= r0_p[i];
                r1_dp[i] <= DP_W'(w_ax[i] * r0_p[i]);
                r1_cp[i] <= DP_W'(w_cos * r0_p[i]);
                r1_kp[i] <= KP_W'(w_ax[i] * w_omc);
            end
            // cross(d, p): x = dy*pz - dz*py, y = dz*px - dx*pz, z = dx*py - dy*px
            r1_xa[0] <= DP_W'(w_ax[1] * r0_p[2]);
            r1_xb[0] <= DP_W'(w_ax[2] * r0_p[1]);
            r1_xa[1] <= DP_W'(w_ax[2] * r0_p[0]);
            r1_xb[1] <= DP_W'(w_ax[0] * r0_p[2]);
            r1_xa[2] <= DP_W'(w_ax[0] * r0_p[1]);
            r1_xb[2] <= DP_W'(w_ax[1] * r0_p[0]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rounding to Q.16 is floor((x + 0.5) / 1.0), done by adding half
    // and keeping the bits above the fraction.
    // ------------------------------------------------------------------
    logic signed [DS_W-1:0] n2_dsum;
    logic signed [CS_W-1:0] n2_csum [3];
    logic signed [KS_W-1:0] n2_ksum [3];
    logic signed [A_W-1:0]  n2_a    [3];

    always_comb begin
        n2_dsum = DS_W'(r1_dp[0]) + DS_W'(r1_dp[1]) + DS_W'(r1_dp[2]) + DS_W'(RND_HALF);
        for (int i = 0; i < 3; i++) begin
            n2_csum[i] = CS_W'(r1_xa[i]) - CS_W'(r1_xb[i]) + CS_W'(RND_HALF);
            n2_ksum[i] = KS_W'(r1_kp[i]) + KS_W'(RND_HALF);
            n2_a[i]    = A_W'(r1_cp[i]) - (A_W'(r1_p[i]) <<< UNIT_FRAC);
        end
    end

    logic [ID_W-1:0]            r2_id;
    logic signed [WEIGHT_W-1:0] r2_w;
    logic signed [DOT_W-1:0]    r2_dot;
    logic signed [CR_W-1:0]     r2_cr [3];
    logic signed [K_W-1:0]      r2_k  [3];
    logic signed [A_W-1:0]      r2_a  [3];

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_id  <= r1_id;
            r2_w   <= r1_w;
            r2_dot <= $signed(n2_dsum[DS_W-1:UNIT_FRAC]);
            for (int i = 0; i < 3; i++) begin
                r2_cr[i] <= $signed(n2_csum[i][CS_W-1:UNIT_FRAC]);
                r2_k[i]  <= $signed(n2_ksum[i][KS_W-1:UNIT_FRAC]);
                r2_a[i]  <= n2_a[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: k*dot and sin*cross.
    // ------------------------------------------------------------------
    logic [ID_W-1:0]            r3_id;
    logic signed [WEIGHT_W-1:0] r3_w;
    logic signed [KD_W-1:0]     r3_kd [3];
    logic signed [SC_W-1:0]     r3_sc [3];
    logic signed [A_W-1:0]      r3_a  [3];

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_id <= r2_id;
            r3_w  <= r2_w;
            for (int i = 0; i < 3; i++) begin
                r3_kd[i] <= KD_W'(r2_k[i] * r2_dot);
                r3_sc[i] <= SC_W'(w_sin * r2_cr[i]);
                r3_a[i]  <= r2_a[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: rotated minus original, rounded to coordinate format.
    // ------------------------------------------------------------------
    logic signed [S_W-1:0] n4_s [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_s[i] = S_W'(r3_a[i]) + S_W'(r3_kd[i]) + S_W'(r3_sc[i]) + S_W'(RND_HALF);
        end
    end

    logic [ID_W-1:0]            r4_id;
    logic signed [WEIGHT_W-1:0] r4_w;
    logic signed [E_W-1:0]      r4_e [3];

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_id <= r3_id;
            r4_w  <= r3_w;
            for (int i = 0; i < 3; i++) begin
                r4_e[i] <= $signed(n4_s[i][UNIT_FRAC +: E_W]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: weight.
    // ------------------------------------------------------------------
    logic [ID_W-1:0]        r5_id;
    logic signed [EW_W-1:0] r5_ew [3];

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_id <= r4_id;
            for (int i = 0; i < 3; i++) begin
                r5_ew[i] <= EW_W'(r4_e[i] * r4_w);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: round, then clamp. The value overflows 32 bits exactly when the
    // bits from the int32 sign bit upward are not all equal.
    // ------------------------------------------------------------------
    logic signed [EW_W:0]   n6_t   [3];
    logic signed [Q_W-1:0]  n6_q   [3];
    logic [COORD_W-1:0]     n6_d   [3];
    logic [2:0]             n6_ovf;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n6_t[i]   = (EW_W + 1)'(r5_ew[i]) + (EW_W + 1)'(RND_HALF);
            n6_q[i]   = $signed(n6_t[i][EW_W:UNIT_FRAC]);
            n6_ovf[i] = !((&n6_q[i][Q_W-1:COORD_W-1]) || !(|n6_q[i][Q_W-1:COORD_W-1]));
            if (n6_ovf[i]) begin
                n6_d[i] = n6_q[i][Q_W-1] ? {1'b1, {(COORD_W - 1){1'b0}}}
                                         : {1'b0, {(COORD_W - 1){1'b1}}};
            end else begin
                n6_d[i] = n6_q[i][COORD_W-1:0];
            end
        end
    end

    logic [ID_W-1:0]    r6_id;
    logic [COORD_W-1:0] r6_disp [3];
    logic               r6_sat;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_id  <= r5_id;
            r6_sat <= |n6_ovf;
            for (int i = 0; i < 3; i++) begin
                r6_disp[i] <= n6_d[i];
            end
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {r6_disp[2], r6_disp[1], r6_disp[0], r6_id};
    assign m_axis_tuser  = r6_sat;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    localparam logic [COORD_W-1:0] DISP_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam logic [COORD_W-1:0] DISP_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

    logic [2:0] w_at_lim;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_at_lim[i] = (r6_disp[i] == DISP_MAX) || (r6_disp[i] == DISP_MIN);
        end
    end

    // An accepted transfer always occupies the first stage on the next cycle.
    `ARD_ASSERT_NXT(a_accept_fills_stage0, s_axis_tvalid && s_axis_tready, r_vld[0])
    // A completely full pipeline with a stalled output must push back on the input.
    `ARD_ASSERT_IMP(a_full_blocks_input, (&r_vld) && !m_axis_tready, !s_axis_tready)
    // A clipped result carries at least one component sitting at a 32-bit limit.
    `ARD_ASSERT_IMP(a_sat_at_limit, m_axis_tvalid && m_axis_tuser[0], |w_at_lim)
    // With nothing in flight and nothing offered, the pipeline stays empty.
    `ARD_ASSERT_NXT(a_idle_stays_empty, !s_axis_tvalid && (r_vld == '0), r_vld == '0)

endmodule

// ----- sv/ard_cfg_regs.sv -----
module ard_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ard_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ard_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ard_pkg::t_cfg                  o_cfg
);
    import ard_pkg::*;

    t_cfg r_cfg;

    // Every write is taken as it arrives, so the port never pushes back.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin <= '0;
            r_cfg.axis   <= '0;
            r_cfg.cos_a  <= COS_RESET;
            r_cfg.sin_a  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_ORIGIN_X: r_cfg.origin[0] <= i_cfg_data[COORD_W-1:0];
                REG_ORIGIN_Y: r_cfg.origin[1] <= i_cfg_data[COORD_W-1:0];
                REG_ORIGIN_Z: r_cfg.origin[2] <= i_cfg_data[COORD_W-1:0];
                REG_AXIS_X:   r_cfg.axis[0]   <= i_cfg_data[UNIT_W-1:0];
                REG_AXIS_Y:   r_cfg.axis[1]   <= i_cfg_data[UNIT_W-1:0];
                REG_AXIS_Z:   r_cfg.axis[2]   <= i_cfg_data[UNIT_W-1:0];
                REG_COS:      r_cfg.cos_a     <= i_cfg_data[UNIT_W-1:0];
                REG_SIN:      r_cfg.sin_a     <= i_cfg_data[UNIT_W-1:0];
            endcase
        end
    end

endmodule

// ----- tb/rotation_scoreboard_pkg.sv -----
`timescale 1ns / 1ps
package rotation_scoreboard_pkg;

    import ard_pkg::*;

    localparam longint UNIT_ONE = longint'(1) << UNIT_FRAC;
    localparam longint DISP_MAX = 64'sd2147483647;
    localparam longint DISP_MIN = -64'sd2147483648;

    typedef struct packed {
        logic                    sat;
        logic [2:0][COORD_W-1:0] disp;
        logic [ID_W-1:0]         id;
    } t_displacement;

    class t_displacement_scoreboard;

        longint        origin [3];
        longint        axis [3];
        longint        cos_a;
        longint        sin_a;
        t_displacement expected_disp_q [$];
        int unsigned   error_count;

        function new();
            for (int i = 0; i < 3; i++) begin
                origin[i] = 0;
                axis[i]   = 0;
            end
            cos_a       = UNIT_ONE;
            sin_a       = 0;
            error_count = 0;
        endfunction

        // Round half toward +infinity, dropping the 16 unit fraction bits.
        static function longint round_q16(longint v);
            return (v + longint'(RND_HALF)) >>> UNIT_FRAC;
        endfunction

        function void write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ORIGIN_X: origin[0] = longint'($signed(data));
                REG_ORIGIN_Y: origin[1] = longint'($signed(data));
                REG_ORIGIN_Z: origin[2] = longint'($signed(data));
                REG_AXIS_X:   axis[0]   = longint'($signed(data[UNIT_W-1:0]));
                REG_AXIS_Y:   axis[1]   = longint'($signed(data[UNIT_W-1:0]));
                REG_AXIS_Z:   axis[2]   = longint'($signed(data[UNIT_W-1:0]));
                REG_COS:      cos_a     = longint'($signed(data[UNIT_W-1:0]));
                REG_SIN:      sin_a     = longint'($signed(data[UNIT_W-1:0]));
            endcase
        endfunction

        function t_displacement predict_displacement(logic [IN_TDATA_W-1:0] beat);
            t_displacement r;
            longint        p [3];
            longint        cr [3];
            longint        w, dot, k, s, e, t;
            r.id  = beat[ID_W-1:0];
            r.sat = 1'b0;
            for (int i = 0; i < 3; i++)
                p[i] = longint'($signed(beat[ID_W + i*COORD_W +: COORD_W])) - origin[i];
            w = longint'($signed(beat[ID_W + 3*COORD_W +: WEIGHT_W]));
            dot   = round_q16(axis[0] * p[0] + axis[1] * p[1] + axis[2] * p[2]);
            cr[0] = round_q16(axis[1] * p[2] - axis[2] * p[1]);
            cr[1] = round_q16(axis[2] * p[0] - axis[0] * p[2]);
            cr[2] = round_q16(axis[0] * p[1] - axis[1] * p[0]);
            for (int i = 0; i < 3; i++) begin
                k = round_q16(axis[i] * (UNIT_ONE - cos_a));
                s = cos_a * p[i] + k * dot + sin_a * cr[i] - UNIT_ONE * p[i];
                e = round_q16(s);
                t = round_q16(e * w);
                if (t > DISP_MAX) begin
                    t     = DISP_MAX;
                    r.sat = 1'b1;
                end
                if (t < DISP_MIN) begin
                    t     = DISP_MIN;
                    r.sat = 1'b1;
                end
                r.disp[i] = COORD_W'(t);
            end
            return r;
        endfunction

        function void note_vertex(logic [IN_TDATA_W-1:0] beat);
            expected_disp_q.push_back(predict_displacement(beat));
        endfunction

        function void check_displacement(logic [OUT_TDATA_W-1:0] beat, logic sat);
            t_displacement      want;
            logic [COORD_W-1:0] got;
            if (expected_disp_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected displacement, id %h, no vertex outstanding",
                         $time, beat[ID_W-1:0]);
                return;
            end
            want = expected_disp_q.pop_front();
            if (beat[ID_W-1:0] !== want.id) begin
                error_count++;
                $display("%0t: out_id expected %h actual %h", $time, want.id, beat[ID_W-1:0]);
            end
            for (int i = 0; i < 3; i++) begin
                got = beat[ID_W + i*COORD_W +: COORD_W];
                if (got !== want.disp[i]) begin
                    error_count++;
                    $display("%0t: id %h disp[%0d] expected %h actual %h",
                             $time, want.id, i, want.disp[i], got);
                end
            end
            if (sat !== want.sat) begin
                error_count++;
                $display("%0t: id %h saturated expected %b actual %b",
                         $time, want.id, want.sat, sat);
            end
        endfunction

        function int pending();
            return expected_disp_q.size();
        endfunction

    endclass

endpackage

// ----- tb/axis_rotation_displacement_core_tb.sv -----
`timescale 1ns / 1ps
module axis_rotation_displacement_core_tb;

    import ard_pkg::*;
    import rotation_scoreboard_pkg::*;

    localparam int CLK_HALF_NS        = 4;
    localparam int RESET_CYCLES       = 9;
    // The core is seven stages deep; the settle wait before a register write and at the
    // end of the run is scaled from that depth.
    localparam int PIPE_LATENCY       = 7;
    localparam int SETTLE_CYCLES      = 3 * PIPE_LATENCY;
    localparam int CYCLE_LIMIT        = 800000;
    localparam int RANDOM_PHASES      = 14;
    localparam int VERTICES_PER_PHASE = 125;

    typedef struct packed {
        logic [WEIGHT_W-1:0] w;
        logic [COORD_W-1:0]  z;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  x;
        logic [ID_W-1:0]     id;
    } t_vertex;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    t_displacement_scoreboard disp_sb;
    t_vertex                  directed_vtx [8];

    // When set, the sender and the receiver run flat out for the whole phase.
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int rx_stall_left = 0;
    int rx_roll;
    int unsigned cycle_count = 0;

    axis_rotation_displacement_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // id, x, y, z, weight from bit 0, zero padded
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // out_id, disp_x, disp_y, disp_z from bit 0
        .m_axis_tuser  (m_axis_tuser)    // saturated
    );

    initial begin
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // The cycle counter is the only way out of a hung run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // All three channels are observed at the clock edge, where every value read is the
    // one that held just before the edge. Register writes and vertex transfers feed the
    // predictor; every displacement transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                disp_sb.write_register(t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                disp_sb.note_vertex(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                disp_sb.check_displacement(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    // Receiver back pressure: mostly ready, with short stalls and the odd long one.
    always @(posedge i_clk) begin
        if (rx_quiet) begin
            m_axis_tready <= 1'b1;
        end else if (rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left--;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 70) begin
                m_axis_tready <= 1'b1;
            end else if (rx_roll < 94) begin
                m_axis_tready <= 1'b0;
                rx_stall_left = $urandom_range(0, 2);
            end else begin
                m_axis_tready <= 1'b0;
                rx_stall_left = $urandom_range(10, 40);
            end
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_vertex(t_vertex v);
        return {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, v.w, v.z, v.y, v.x, v.id};
    endfunction

    // Idle cycles ahead of the next vertex: mostly none, a few short, rarely long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_quiet || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Coordinates are mostly moderate, so that results do not always clip, with full
    // range values and the corners of the range mixed in.
    function automatic logic [COORD_W-1:0] rand_coord();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
        if (roll < 80)
            return $urandom;
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            default: return 32'h0001_0000;
        endcase
    endfunction

    // A weight of 1.0 is what the host sends when there is no filter, so it is common.
    function automatic logic [WEIGHT_W-1:0] rand_weight();
        int          roll;
        logic [31:0] bits;
        roll = $urandom_range(0, 99);
        bits = $urandom;
        if (roll < 40)
            return 18'h10000;
        if (roll < 50)
            return 18'h00000;
        if (roll < 90)
            return bits[WEIGHT_W-1:0];
        if (roll < 95)
            return 18'h1FFFF;
        return 18'h20000;
    endfunction

    function automatic t_vertex random_vertex();
        t_vertex v;
        v.id = $urandom;
        v.x  = rand_coord();
        v.y  = rand_coord();
        v.z  = rand_coord();
        v.w  = rand_weight();
        return v;
    endfunction

    // An 18-bit register is written either sign extended or with junk in the unused bits,
    // which the core has to ignore.
    function automatic logic [CFG_DATA_W-1:0] widen_unit(logic [UNIT_W-1:0] v, bit junk);
        logic [31:0] bits;
        bits = $urandom;
        if (junk)
            return {bits[CFG_DATA_W-1:UNIT_W], v};
        return {{(CFG_DATA_W - UNIT_W){v[UNIT_W-1]}}, v};
    endfunction

    // One register write. The valid stays high afterwards so that back-to-back writes
    // never lower and raise it within the same step; the caller drops it at the end.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
    endtask

    task automatic load_axis_setup(logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy,
                                   logic [COORD_W-1:0] oz, logic [UNIT_W-1:0] ax,
                                   logic [UNIT_W-1:0] ay, logic [UNIT_W-1:0] az,
                                   logic [UNIT_W-1:0] c, logic [UNIT_W-1:0] s, bit junk);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_AXIS_X, widen_unit(ax, junk));
        write_reg(REG_AXIS_Y, widen_unit(ay, junk));
        write_reg(REG_AXIS_Z, widen_unit(az, junk));
        write_reg(REG_COS, widen_unit(c, junk));
        write_reg(REG_SIN, widen_unit(s, junk));
        i_cfg_valid <= 1'b0;
    endtask

    // Offers one vertex after the given number of idle cycles and returns at the edge
    // where the transfer happens. The valid is only lowered when a gap comes first.
    task automatic send_vertex(t_vertex v, int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_vertex(v);
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    // Stops sending and waits until every predicted displacement has been taken, then
    // lets the pipeline settle. The first edge lets the monitor record the last vertex.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (disp_sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Picks a new rotation for a random phase. Real use has a unit axis with a matching
    // cosine and sine; the other modes draw unit values within [-1, 1], from the whole range
    // of every register and at its corners, including unit values above one and non-unit axes.
    task automatic random_setup();
        int                 mode, pick, tmp;
        logic [COORD_W-1:0] org [3];
        logic [UNIT_W-1:0]  ax [3];
        logic [UNIT_W-1:0]  c, s;
        logic [31:0]        bits;
        mode = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++) begin
            org[i] = (mode == 0) ? rand_coord() : $urandom;
            ax[i]  = '0;
        end
        case (mode)
            0: begin
                if ($urandom_range(0, 3) == 0) begin
                    // Body diagonal, about 1/sqrt(3) per component.
                    for (int i = 0; i < 3; i++)
                        ax[i] = $urandom_range(0, 1) ? 18'(37837) : 18'(-37837);
                end else begin
                    pick = $urandom_range(0, 2);
                    ax[pick] = $urandom_range(0, 1) ? 18'(65536) : 18'(-65536);
                end
                case ($urandom_range(0, 5))
                    0: begin c = 18'(65536);  s = 18'(0);      end
                    1: begin c = 18'(0);      s = 18'(65536);  end
                    2: begin c = 18'(-65536); s = 18'(0);      end
                    3: begin c = 18'(46341);  s = 18'(46341);  end
                    4: begin c = 18'(56756);  s = 18'(32768);  end
                    default: begin c = 18'(46341); s = 18'(-46341); end
                endcase
            end
            1: begin
                for (int i = 0; i < 3; i++) begin
                    tmp   = int'($urandom_range(0, 131072)) - 65536;
                    ax[i] = UNIT_W'(tmp);
                end
                tmp = int'($urandom_range(0, 131072)) - 65536;
                c   = UNIT_W'(tmp);
                tmp = int'($urandom_range(0, 131072)) - 65536;
                s   = UNIT_W'(tmp);
            end
            2: begin
                for (int i = 0; i < 3; i++) begin
                    bits  = $urandom;
                    ax[i] = bits[UNIT_W-1:0];
                end
                bits = $urandom;
                c    = bits[UNIT_W-1:0];
                bits = $urandom;
                s    = bits[UNIT_W-1:0];
            end
            default: begin
                // Corners of every register.
                for (int i = 0; i < 3; i++) begin
                    case ($urandom_range(0, 2))
                        0: org[i] = 32'h7FFF_FFFF;
                        1: org[i] = 32'h8000_0000;
                        default: org[i] = 32'h0000_0000;
                    endcase
                    case ($urandom_range(0, 3))
                        0: ax[i] = 18'h1FFFF;
                        1: ax[i] = 18'h20000;
                        2: ax[i] = 18'h10000;
                        default: ax[i] = 18'h30000;
                    endcase
                end
                c = $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
                s = $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
            end
        endcase
        load_axis_setup(org[0], org[1], org[2], ax[0], ax[1], ax[2], c, s,
                        1'($urandom_range(0, 1)));
    endtask

    initial begin
        disp_sb = new();

        // Directed vertices: all zero, both corners of every field, mixed signs, exact
        // unit points, and halves that land right on the rounding boundary.
        directed_vtx[0] = '{w: 18'h10000, z: 32'h0, y: 32'h0, x: 32'h0, id: 32'h0};
        directed_vtx[1] = '{w: 18'h1FFFF, z: 32'h7FFF_FFFF, y: 32'h7FFF_FFFF,
                            x: 32'h7FFF_FFFF, id: 32'hFFFF_FFFF};
        directed_vtx[2] = '{w: 18'h20000, z: 32'h8000_0000, y: 32'h8000_0000,
                            x: 32'h8000_0000, id: 32'h1};
        directed_vtx[3] = '{w: 18'h10000, z: 32'h0, y: 32'h8000_0000,
                            x: 32'h7FFF_FFFF, id: 32'h2};
        directed_vtx[4] = '{w: 18'h10000, z: 32'h0, y: 32'h0, x: 32'h0001_0000, id: 32'h3};
        directed_vtx[5] = '{w: 18'h00000, z: 32'hFFFF_0000, y: 32'h0001_0000, x: 32'h0,
                            id: 32'h4};
        directed_vtx[6] = '{w: 18'h08000, z: 32'h0000_8000, y: 32'h0000_0001,
                            x: 32'hFFFF_FFFF, id: 32'h5};
        directed_vtx[7] = '{w: 18'h30000, z: 32'h00AB_CDEF, y: 32'hEDCB_A987,
                            x: 32'h1234_5678, id: 32'h6};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // With the reset registers (cosine 1.0, everything else zero) every displacement
        // must come out as zero.
        for (int i = 0; i < 6; i++)
            send_vertex(directed_vtx[i], pick_gap());
        wait_drained();

        // Corner registers: origin at both ends, unit values outside [-1, 1] and a
        // non-unit axis, so that most results clip.
        load_axis_setup(32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                        18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h20000, 18'h1FFFF, 1'b0);
        for (int i = 0; i < 8; i++)
            send_vertex(directed_vtx[i], pick_gap());
        wait_drained();

        // A plain quarter turn about z around the point (1.0, 2.0, 0).
        load_axis_setup(32'h0001_0000, 32'h0002_0000, 32'h0,
                        18'h0, 18'h0, 18'h10000, 18'h0, 18'h10000, 1'b0);
        for (int i = 0; i < 8; i++)
            send_vertex(directed_vtx[i], pick_gap());
        wait_drained();

        // Random phases, each under its own rotation. Every fourth phase runs without any
        // idling on either side, and some phases stop halfway until the pipeline is empty.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            tx_quiet = (ph % 4 == 1);
            rx_quiet = tx_quiet;
            random_setup();
            for (int n = 0; n < VERTICES_PER_PHASE; n++) begin
                if (n == VERTICES_PER_PHASE / 2 && (ph == 0 || $urandom_range(0, 2) == 0))
                    wait_drained();
                send_vertex(random_vertex(), pick_gap());
            end
            wait_drained();
        end

        if (disp_sb.error_count == 0 && disp_sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
